// File: rtl/simplex_noise_2d_fractal_core_assert.svh
// assertion macros shared by the noise core modules
`ifndef SIMPLEX_NOISE_2D_FRACTAL_CORE_ASSERT_SVH
`define SIMPLEX_NOISE_2D_FRACTAL_CORE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define SNF_AST_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define SNF_AST_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/snf_pkg.sv
package snf_pkg;

  typedef enum logic [4:0] {
    ST_IDLE, ST_SX, ST_SY, ST_SKEW, ST_CELL, ST_UNSKEW, ST_OFFS,
    ST_CSETUP, ST_CHASH, ST_CR2A, ST_CR2B, ST_CT2, ST_CT4, ST_CG, ST_CACC,
    ST_OCT_N, ST_OCT_F, ST_OCT_A, ST_OCT_E, ST_FIN
  } snf_state_t;

  typedef enum logic [2:0] {
    CFG_MODE, CFG_BASE_FREQ, CFG_LACUNARITY, CFG_GAIN, CFG_OCT_COUNT
  } snf_cfg_idx_t;

  localparam int MUL_AW = 42;
  localparam int MUL_BW = 28;
  localparam int MUL_PW = MUL_AW + MUL_BW;

  localparam logic signed [27:0] SKEW_F2   = 28'sd383805;
  localparam logic signed [27:0] UNSKEW_G2 = 28'sd221590;
  localparam logic signed [27:0] G2_X2     = 28'sd443180;
  localparam logic signed [27:0] ONE_Q20   = 28'sd1048576;
  localparam logic [35:0]        HALF_Q20  = 36'd524288;
  localparam logic [23:0]        AMP_ONE   = 24'h010000;
  localparam logic [1:0]         LAST_CORNER = 2'd2;

  typedef struct packed {
    logic start;
    logic zero_oct;
    logic t_neg;
    logic oct_last;
    logic out_free;
  } snf_stat_t;

  typedef struct packed {
    snf_state_t state;
    logic [1:0] corner;
  } snf_ctl_t;

  localparam logic [7:0] PERM [256] = '{
    8'd151,8'd160,8'd137,8'd91,8'd90,8'd15,8'd131,8'd13,8'd201,8'd95,8'd96,8'd53,
    8'd194,8'd233,8'd7,8'd225,8'd140,8'd36,8'd103,8'd30,8'd69,8'd142,8'd8,8'd99,
    8'd37,8'd240,8'd21,8'd10,8'd23,8'd190,8'd6,8'd148,8'd247,8'd120,8'd234,8'd75,
    8'd0,8'd26,8'd197,8'd62,8'd94,8'd252,8'd219,8'd203,8'd117,8'd35,8'd11,8'd32,
    8'd57,8'd177,8'd33,8'd88,8'd237,8'd149,8'd56,8'd87,8'd174,8'd20,8'd125,8'd136,
    8'd171,8'd168,8'd68,8'd175,8'd74,8'd165,8'd71,8'd134,8'd139,8'd48,8'd27,8'd166,
    8'd77,8'd146,8'd158,8'd231,8'd83,8'd111,8'd229,8'd122,8'd60,8'd211,8'd133,8'd230,
    8'd220,8'd105,8'd92,8'd41,8'd55,8'd46,8'd245,8'd40,8'd244,8'd102,8'd143,8'd54,
    8'd65,8'd25,8'd63,8'd161,8'd1,8'd216,8'd80,8'd73,8'd209,8'd76,8'd132,8'd187,
    8'd208,8'd89,8'd18,8'd169,8'd200,8'd196,8'd135,8'd130,8'd116,8'd188,8'd159,8'd86,
    8'd164,8'd100,8'd109,8'd198,8'd173,8'd186,8'd3,8'd64,8'd52,8'd217,8'd226,8'd250,
    8'd124,8'd123,8'd5,8'd202,8'd38,8'd147,8'd118,8'd126,8'd255,8'd82,8'd85,8'd212,
    8'd207,8'd206,8'd59,8'd227,8'd47,8'd16,8'd58,8'd17,8'd182,8'd189,8'd28,8'd42,
    8'd223,8'd183,8'd170,8'd213,8'd119,8'd248,8'd152,8'd2,8'd44,8'd154,8'd163,8'd70,
    8'd221,8'd153,8'd101,8'd155,8'd167,8'd43,8'd172,8'd9,8'd129,8'd22,8'd39,8'd253,
    8'd19,8'd98,8'd108,8'd110,8'd79,8'd113,8'd224,8'd232,8'd178,8'd185,8'd112,8'd104,
    8'd218,8'd246,8'd97,8'd228,8'd251,8'd34,8'd242,8'd193,8'd238,8'd210,8'd144,8'd12,
    8'd191,8'd179,8'd162,8'd241,8'd81,8'd51,8'd145,8'd235,8'd249,8'd14,8'd239,8'd107,
    8'd49,8'd192,8'd214,8'd31,8'd181,8'd199,8'd106,8'd157,8'd184,8'd84,8'd204,8'd176,
    8'd115,8'd121,8'd50,8'd45,8'd127,8'd4,8'd150,8'd254,8'd138,8'd236,8'd205,8'd93,
    8'd222,8'd114,8'd67,8'd29,8'd24,8'd72,8'd243,8'd141,8'd128,8'd195,8'd78,8'd66,
    8'd215,8'd61,8'd156,8'd180
  };

endpackage

// File: rtl/snf_mul.sv
module snf_mul (
  input  logic                                 clk,
  input  logic signed [snf_pkg::MUL_AW-1:0]    a,
  input  logic signed [snf_pkg::MUL_BW-1:0]    b,
  output logic signed [snf_pkg::MUL_PW-1:0]    p
);
  import snf_pkg::*;

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

// File: rtl/snf_seq.sv
`include "simplex_noise_2d_fractal_core_assert.svh"

module snf_seq (
  input  logic               clk,
  input  logic               rst,
  input  snf_pkg::snf_stat_t stat,
  output snf_pkg::snf_ctl_t  ctl
);
  import snf_pkg::*;

  snf_state_t state, state_next;
  logic [1:0] corner, corner_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      corner <= 2'd0;
    end else begin
      state  <= state_next;
      corner <= corner_next;
    end
  end

  always_comb begin
    state_next  = state;
    corner_next = corner;
    case (state)
      ST_IDLE:   if (stat.start) state_next = stat.zero_oct ? ST_FIN : ST_SX;
      ST_SX:     state_next = ST_SY;
      ST_SY:     state_next = ST_SKEW;
      ST_SKEW:   state_next = ST_CELL;
      ST_CELL:   state_next = ST_UNSKEW;
      ST_UNSKEW: state_next = ST_OFFS;
      ST_OFFS: begin
        state_next  = ST_CSETUP;
        corner_next = 2'd0;
      end
      ST_CSETUP: state_next = ST_CHASH;
      ST_CHASH:  state_next = ST_CR2A;
      ST_CR2A:   state_next = ST_CR2B;
      ST_CR2B: begin
        // corner outside the falloff radius adds nothing
        if (!stat.t_neg) begin
          state_next = ST_CT2;
        end else if (corner == LAST_CORNER) begin
          state_next = ST_OCT_N;
        end else begin
          state_next  = ST_CSETUP;
          corner_next = corner + 2'd1;
        end
      end
      ST_CT2:    state_next = ST_CT4;
      ST_CT4:    state_next = ST_CG;
      ST_CG:     state_next = ST_CACC;
      ST_CACC: begin
        if (corner == LAST_CORNER) begin
          state_next = ST_OCT_N;
        end else begin
          state_next  = ST_CSETUP;
          corner_next = corner + 2'd1;
        end
      end
      ST_OCT_N:  state_next = ST_OCT_F;
      ST_OCT_F:  state_next = ST_OCT_A;
      ST_OCT_A:  state_next = ST_OCT_E;
      ST_OCT_E:  state_next = stat.oct_last ? ST_FIN : ST_SX;
      ST_FIN:    if (stat.out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl.state  = state;
    ctl.corner = corner;
  end

  `SNF_AST_NEXT(a_last_corner_acc, (state == ST_CACC && corner == LAST_CORNER),
    state == ST_OCT_N, "last corner did not close the octave")
  `SNF_AST_NEXT(a_corner_step, (state == ST_CACC && corner != LAST_CORNER),
    (state == ST_CSETUP && corner == $past(corner) + 2'd1), "corner did not advance")
  `SNF_AST_NEXT(a_skip_last, (state == ST_CR2B && stat.t_neg && corner == LAST_CORNER),
    state == ST_OCT_N, "skipped last corner did not close the octave")

endmodule

// File: rtl/simplex_noise_2d_fractal_core.sv
// fractal 2d simplex noise core (fbm or turbulence)
// input channel: in_valid/in_ready with x_coord, y_coord (signed q16.16); one
// transfer starts one sample. output channel: out_valid/out_ready with
// noise_value (signed q8.24, saturated), one result per sample, in order.
// config channel: cfg_valid/cfg_ready (always ready), cfg_index selects mode,
// base frequency, lacunarity, gain or octave count; other indexes are ignored.
// write config only while no sample is in flight.
// each octave runs skew, cell, unskew and offsets, then three corners (hash
// and squared distance, plus falloff power and gradient term for a corner
// inside the falloff radius), then octave scale and updates. one shared
// 42x28 multiplier serves up to 22 dependent products per octave.
// in_ready is high only between samples, so one sample is worked at a time.
// a finished result sits in the output register; a stalled receiver holds it
// there, a new sample is taken meanwhile and waits at the end for the register.
// reset restores the config registers to their defaults and drops any result.
// zero octaves gives a zero result without running an octave.
`include "simplex_noise_2d_fractal_core_assert.svh"

module simplex_noise_2d_fractal_core #(
  parameter int MAX_OCTAVES = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] x_coord,
  input  logic signed [31:0] y_coord,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] noise_value,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [23:0]        cfg_data
);
  import snf_pkg::*;

  localparam int CW = $clog2(MAX_OCTAVES + 1);

  snf_stat_t stat;
  snf_ctl_t  ctl;

  logic        mode;
  logic [23:0] base_freq, lac, gain;
  logic [4:0]  oct_count;

  logic signed [31:0] xr, yr;
  logic [23:0]        freq, amp;
  logic [CW-1:0]      cnt, oct, cnt_c;
  logic signed [39:0] sx, sy, sy_c;
  logic signed [40:0] s_c;
  logic signed [41:0] sum_i, sum_j;
  logic signed [25:0] ic, jc;
  logic signed [26:0] ij_sum;
  logic signed [45:0] t_c;
  logic signed [47:0] x0_full, y0_full;
  logic signed [27:0] x0, y0, dx, dy, dx_c, dy_c;
  logic               i1, ik, jk;
  logic [7:0]         pj, hash, pj_idx, hash_idx;
  logic [55:0]        r2, r2s;
  logic [19:0]        tr;
  logic signed [28:0] u, v;
  logic signed [29:0] g, g_c;
  logic signed [48:0] sum;
  logic signed [41:0] c_c, cabs;
  logic signed [47:0] total;
  logic signed [31:0] sat_c;
  logic [23:0]        prod_sat;
  logic               out_free;

  logic signed [MUL_AW-1:0] ma;
  logic signed [MUL_BW-1:0] mb;
  logic signed [MUL_PW-1:0] prod;

  snf_mul u_mul (
    .clk (clk),
    .a   (ma),
    .b   (mb),
    .p   (prod)
  );

  snf_seq u_seq (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .ctl  (ctl)
  );

  assign in_ready  = (ctl.state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || out_ready;
  assign cnt_c     = (32'(oct_count) > 32'(MAX_OCTAVES)) ? CW'(MAX_OCTAVES) : CW'(oct_count);

  // cell and offsets
  assign sy_c    = prod[55:16];
  assign s_c     = prod[60:20];
  assign sum_i   = {{2{sx[39]}}, sx} + {s_c[40], s_c};
  assign sum_j   = {{2{sy[39]}}, sy} + {s_c[40], s_c};
  assign ij_sum  = {ic[25], ic} + {jc[25], jc};
  assign t_c     = prod[45:0];
  assign x0_full = {{4{sx[39]}}, sx, 4'b0} - {{2{ic[25]}}, ic, 20'b0} + {{2{t_c[45]}}, t_c};
  assign y0_full = {{4{sy[39]}}, sy, 4'b0} - {{2{jc[25]}}, jc, 20'b0} + {{2{t_c[45]}}, t_c};

  // corner offsets and hash
  assign i1 = (x0 > y0);
  always_comb begin
    case (ctl.corner)
      2'd0: begin
        dx_c = x0;
        dy_c = y0;
        ik   = 1'b0;
        jk   = 1'b0;
      end
      2'd1: begin
        dx_c = x0 - (i1 ? ONE_Q20 : 28'sd0) + UNSKEW_G2;
        dy_c = y0 - (i1 ? 28'sd0 : ONE_Q20) + UNSKEW_G2;
        ik   = i1;
        jk   = !i1;
      end
      default: begin
        dx_c = x0 - ONE_Q20 + G2_X2;
        dy_c = y0 - ONE_Q20 + G2_X2;
        ik   = 1'b1;
        jk   = 1'b1;
      end
    endcase
  end
  assign pj_idx   = jc[7:0] + {7'b0, jk};
  assign hash_idx = ic[7:0] + {7'b0, ik} + pj;

  // gradient dot product
  always_comb begin
    u = hash[2] ? {dy[27], dy} : {dx[27], dx};
    v = hash[2] ? {dx, 1'b0} : {dy, 1'b0};
    if (hash[0]) u = -u;
    if (hash[1]) v = -v;
    g_c = {u[28], u} + {v[28], v};
  end

  assign r2s = r2 + prod[55:0];

  assign c_c  = prod[57:16];
  assign cabs = (mode && c_c[41]) ? -c_c : c_c;

  assign prod_sat = (|prod[47:40]) ? 24'hFFFFFF : prod[39:16];

  always_comb begin
    if (total[47:31] == '0 || total[47:31] == '1) begin
      sat_c = total[31:0];
    end else begin
      sat_c = total[47] ? 32'sh80000000 : 32'sh7FFFFFFF;
    end
  end

  // shared multiplier operand select
  always_comb begin
    ma = '0;
    mb = '0;
    case (ctl.state)
      ST_SX: begin
        ma = {{10{xr[31]}}, xr};
        mb = {4'b0, freq};
      end
      ST_SY: begin
        ma = {{10{yr[31]}}, yr};
        mb = {4'b0, freq};
      end
      ST_SKEW: begin
        ma = {{2{sx[39]}}, sx} + {{2{sy_c[39]}}, sy_c};
        mb = SKEW_F2;
      end
      ST_UNSKEW: begin
        ma = {{15{ij_sum[26]}}, ij_sum};
        mb = UNSKEW_G2;
      end
      ST_CHASH: begin
        ma = {{14{dx[27]}}, dx};
        mb = dx;
      end
      ST_CR2A: begin
        ma = {{14{dy[27]}}, dy};
        mb = dy;
      end
      ST_CT2: begin
        ma = {22'b0, tr};
        mb = {8'b0, tr};
      end
      ST_CT4: begin
        ma = {22'b0, prod[39:20]};
        mb = {8'b0, prod[39:20]};
      end
      ST_CG: begin
        ma = {{12{g[29]}}, g};
        mb = {8'b0, prod[39:20]};
      end
      ST_OCT_N: begin
        ma = {{9{sum[48]}}, sum[48:16]};
        mb = {4'b0, amp};
      end
      ST_OCT_F: begin
        ma = {18'b0, freq};
        mb = {4'b0, lac};
      end
      ST_OCT_A: begin
        ma = {18'b0, amp};
        mb = {4'b0, gain};
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  always_comb begin
    stat.start    = in_valid && in_ready;
    stat.zero_oct = (cnt_c == '0);
    stat.t_neg    = (r2s[55:20] > HALF_Q20);
    stat.oct_last = (oct == cnt - CW'(1));
    stat.out_free = out_free;
  end

  // control and config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= 1'b0;
      base_freq <= 24'd65536;
      lac       <= 24'd131072;
      gain      <= 24'd32768;
      oct_count <= 5'd4;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CFG_MODE:       mode      <= cfg_data[0];
          CFG_BASE_FREQ:  base_freq <= cfg_data;
          CFG_LACUNARITY: lac       <= cfg_data;
          CFG_GAIN:       gain      <= cfg_data;
          CFG_OCT_COUNT:  oct_count <= cfg_data[4:0];
          default: ;
        endcase
      end
      if (ctl.state == ST_FIN && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (ctl.state)
      ST_IDLE: begin
        if (in_valid) begin
          xr    <= x_coord;
          yr    <= y_coord;
          freq  <= base_freq;
          amp   <= AMP_ONE;
          cnt   <= cnt_c;
          oct   <= '0;
          total <= '0;
        end
      end
      ST_SY:   sx <= prod[55:16];
      ST_SKEW: sy <= sy_c;
      ST_CELL: begin
        ic <= sum_i[41:16];
        jc <= sum_j[41:16];
      end
      ST_OFFS: begin
        x0  <= x0_full[27:0];
        y0  <= y0_full[27:0];
        sum <= '0;
      end
      ST_CSETUP: begin
        dx <= dx_c;
        dy <= dy_c;
        pj <= PERM[pj_idx];
      end
      ST_CHASH: hash <= PERM[hash_idx];
      ST_CR2A:  r2 <= prod[55:0];
      ST_CR2B: begin
        tr <= 20'(HALF_Q20 - r2s[55:20]);
        g  <= g_c;
      end
      ST_CACC:  sum <= sum + prod[48:0];
      ST_OCT_F: total <= total + {{6{cabs[41]}}, cabs};
      ST_OCT_A: freq <= prod_sat;
      ST_OCT_E: begin
        amp <= prod_sat;
        oct <= oct + CW'(1);
      end
      ST_FIN:   if (out_free) noise_value <= sat_c;
      default: ;
    endcase
  end

  `SNF_AST_NEXT(a_start_octave, (in_valid && in_ready && cnt_c != '0),
    ctl.state == ST_SX, "sample transfer did not start an octave")
  `SNF_AST_NEXT(a_point_held, (ctl.state != ST_IDLE),
    ($stable(xr) && $stable(yr)), "sample point changed while busy")
  `SNF_AST_SAME(a_oct_range, (ctl.state == ST_SX), (oct < cnt),
    "octave index beyond octave count")

endmodule
